// ===== rtl/integer_to_roman_encoder_core_macros.svh =====
// Assertion macros shared by the integer-to-Roman checker.
`ifndef INTEGER_TO_ROMAN_ENCODER_CORE_MACROS_SVH
`define INTEGER_TO_ROMAN_ENCODER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define I2R_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("i2r: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define I2R_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("i2r: next-cycle check failed");

`endif

// ===== rtl/i2r_pkg.sv =====
// Package for the integer-to-Roman encoder: codes, control words and the microprogram.
`default_nettype none
package i2r_pkg;

	localparam int unsigned VALUE_W  = 12;
	localparam int unsigned LETTER_W = 7;
	localparam int unsigned PC_W     = 5;

	localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd3999;

	localparam logic [LETTER_W-1:0] CH_NONE = 7'h00;
	localparam logic [LETTER_W-1:0] CH_I    = 7'h49;
	localparam logic [LETTER_W-1:0] CH_V    = 7'h56;
	localparam logic [LETTER_W-1:0] CH_X    = 7'h58;
	localparam logic [LETTER_W-1:0] CH_L    = 7'h4C;
	localparam logic [LETTER_W-1:0] CH_C    = 7'h43;
	localparam logic [LETTER_W-1:0] CH_D    = 7'h44;
	localparam logic [LETTER_W-1:0] CH_M    = 7'h4D;

	typedef logic [PC_W-1:0]     pc_t;
	typedef logic [VALUE_W-1:0]  value_t;
	typedef logic [LETTER_W-1:0] letter_t;

	// RANGE: flag a bad value; TEST: emit and subtract if remainder >= k (repeating for M, C, X, I);
	// HEAD: first letter of a subtractive pair; TAIL: second letter, subtract k.
	typedef enum logic [1:0] {
		OP_RANGE,
		OP_TEST,
		OP_HEAD,
		OP_TAIL
	} op_t;

	typedef struct packed {
		op_t     op;
		value_t  kval;
		letter_t letter;
		pc_t     jt;
		pc_t     jf;
	} uword_t;

	// Sequencer to datapath.
	typedef struct packed {
		logic    load;
		logic    fire;
		logic    sub;
		value_t  kval;
		letter_t letter;
		logic    last;
		logic    oor;
	} ctrl_t;

	// Datapath to sequencer.
	typedef struct packed {
		logic ge;
		logic eq;
		logic oor;
		logic out_free;
	} stat_t;

	function automatic uword_t i2r_ucode(input pc_t pc);
		uword_t w;
		unique case (pc)
			5'd0:    w = '{OP_RANGE, 12'd0,    CH_NONE, 5'd0,  5'd1};
			5'd1:    w = '{OP_TEST,  12'd1000, CH_M,    5'd1,  5'd2};
			5'd2:    w = '{OP_HEAD,  12'd900,  CH_C,    5'd3,  5'd4};
			5'd3:    w = '{OP_TAIL,  12'd900,  CH_M,    5'd8,  5'd8};
			5'd4:    w = '{OP_TEST,  12'd500,  CH_D,    5'd7,  5'd5};
			5'd5:    w = '{OP_HEAD,  12'd400,  CH_C,    5'd6,  5'd7};
			5'd6:    w = '{OP_TAIL,  12'd400,  CH_D,    5'd8,  5'd8};
			5'd7:    w = '{OP_TEST,  12'd100,  CH_C,    5'd7,  5'd8};
			5'd8:    w = '{OP_HEAD,  12'd90,   CH_X,    5'd9,  5'd10};
			5'd9:    w = '{OP_TAIL,  12'd90,   CH_C,    5'd14, 5'd14};
			5'd10:   w = '{OP_TEST,  12'd50,   CH_L,    5'd13, 5'd11};
			5'd11:   w = '{OP_HEAD,  12'd40,   CH_X,    5'd12, 5'd13};
			5'd12:   w = '{OP_TAIL,  12'd40,   CH_L,    5'd14, 5'd14};
			5'd13:   w = '{OP_TEST,  12'd10,   CH_X,    5'd13, 5'd14};
			5'd14:   w = '{OP_HEAD,  12'd9,    CH_I,    5'd15, 5'd16};
			5'd15:   w = '{OP_TAIL,  12'd9,    CH_X,    5'd16, 5'd16};
			5'd16:   w = '{OP_TEST,  12'd5,    CH_V,    5'd18, 5'd17};
			5'd17:   w = '{OP_HEAD,  12'd4,    CH_I,    5'd19, 5'd18};
			5'd18:   w = '{OP_TEST,  12'd1,    CH_I,    5'd18, 5'd18};
			5'd19:   w = '{OP_TAIL,  12'd4,    CH_V,    5'd18, 5'd18};
			default: w = '{OP_RANGE, 12'd0,    CH_NONE, 5'd0,  5'd0};
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/i2r_seq.sv =====
// Microprogram sequencer: step counter, control ROM and branch logic.
`default_nettype none
module i2r_seq
	import i2r_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire stat_t stat,
	output ctrl_t      ctrl
);

	logic   busy_q;
	pc_t    pc_q;
	uword_t uw;
	logic   taken;
	logic   lst;
	logic   do_sub;
	logic   emit;
	logic   stall;

	assign in_ready = !busy_q;

	always_comb begin
		uw = i2r_ucode(pc_q);
		unique case (uw.op)
			OP_RANGE: begin
				taken  = stat.oor;
				lst    = 1'b1;
				do_sub = 1'b0;
			end
			OP_TEST: begin
				taken  = stat.ge;
				lst    = stat.eq;
				do_sub = 1'b1;
			end
			OP_HEAD: begin
				taken  = stat.ge;
				lst    = 1'b0;
				do_sub = 1'b0;
			end
			OP_TAIL: begin
				taken  = 1'b1;
				lst    = stat.eq;
				do_sub = 1'b1;
			end
			default: begin
				taken  = 1'b0;
				lst    = 1'b0;
				do_sub = 1'b0;
			end
		endcase
		emit        = busy_q & taken;
		stall       = emit & !stat.out_free;
		ctrl.load   = in_valid & !busy_q;
		ctrl.fire   = emit & stat.out_free;
		ctrl.sub    = emit & stat.out_free & do_sub;
		ctrl.kval   = uw.kval;
		ctrl.letter = uw.letter;
		ctrl.last   = lst;
		ctrl.oor    = (uw.op == OP_RANGE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
		end else if (ctrl.load) begin
			busy_q <= 1'b1;
			pc_q   <= '0;
		end else if (busy_q && !stall) begin
			pc_q <= taken ? uw.jt : uw.jf;
			// drop busy once the final letter transfers into the output register
			if (ctrl.fire && lst) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/i2r_dpath.sv =====
// Datapath: remainder register, compare against the step constant, output register.
`default_nettype none
module i2r_dpath
	import i2r_pkg::*;
(
	input  wire            clk,
	input  wire            arst_n,
	input  wire  [11:0]    value,
	input  wire  ctrl_t    ctrl,
	output stat_t          stat,
	output logic           out_valid,
	input  wire            out_ready,
	output logic [6:0]     letter,
	output logic           last,
	output logic           out_of_range
);

	value_t  rem_q;
	logic    out_valid_q;
	letter_t letter_q;
	logic    last_q;
	logic    oor_q;

	assign stat.ge       = (rem_q >= ctrl.kval);
	assign stat.eq       = (rem_q == ctrl.kval);
	assign stat.oor      = (rem_q == '0) || (rem_q > MAX_VALUE);
	assign stat.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			rem_q <= value;
		end else if (ctrl.sub) begin
			rem_q <= rem_q - ctrl.kval;
		end
		if (ctrl.fire) begin
			letter_q <= ctrl.letter;
			last_q   <= ctrl.last;
			oor_q    <= ctrl.oor;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign letter       = letter_q;
	assign last         = last_q;
	assign out_of_range = oor_q;

endmodule
`default_nettype wire

// ===== rtl/integer_to_roman_encoder_core.sv =====
// Top level of the integer-to-Roman encoder.
// Converts one 12-bit value to its Roman numeral, one ASCII letter per output
// transfer, most significant first, with last on the final letter. A value of
// 0 or above 3999 gives a single transfer with letter 0, last and out_of_range.
// A microprogram of 20 control words walks the greedy pattern table (M, CM, D,
// CD, C, ... IV, I), one word per cycle, but a word that emits a letter waits
// while the output register holds an untaken letter: each letter uses one
// word and each pattern test that does not match uses one more. The next
// value is taken once the final letter sits in the output register, while
// that letter still waits.
`default_nettype none
module integer_to_roman_encoder_core
	import i2r_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire [11:0] value,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [6:0] letter,
	output logic       last,
	output logic       out_of_range
);

	ctrl_t ctrl;
	stat_t stat;

	i2r_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	i2r_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.value        (value),
		.ctrl         (ctrl),
		.stat         (stat),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.letter       (letter),
		.last         (last),
		.out_of_range (out_of_range)
	);

endmodule
`default_nettype wire

// ===== rtl/i2r_checker.sv =====
// Port-level checker for the integer-to-Roman encoder, bound to the top level.
`default_nettype none
`include "integer_to_roman_encoder_core_macros.svh"
module i2r_checker
	import i2r_pkg::*;
(
	input wire       clk,
	input wire       arst_n,
	input wire       in_valid,
	input wire       in_ready,
	input wire       out_valid,
	input wire       out_ready,
	input wire [6:0] letter,
	input wire       last,
	input wire       out_of_range
);

	`I2R_ASSERT_IMP(a_oor_single, clk, arst_n, out_valid && out_of_range, last && (letter == CH_NONE))

	`I2R_ASSERT_IMP(a_letter_legal, clk, arst_n, out_valid && !out_of_range, (letter == CH_I) || (letter == CH_V) || (letter == CH_X) || (letter == CH_L) || (letter == CH_C) || (letter == CH_D) || (letter == CH_M))

	`I2R_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

	`I2R_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(letter) && $stable(last) && $stable(out_of_range))

endmodule

bind integer_to_roman_encoder_core i2r_checker u_i2r_checker (.*);
`default_nettype wire

// ===== bench/integer_to_roman_encoder_core_test.sv =====
// Testbench for the integer-to-Roman encoder: numeral scoreboard, value stimulus and letter checks.
module integer_to_roman_encoder_core_test;
	import i2r_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 30;
	localparam int IDLE_PCT = 23;

	typedef struct packed {
		letter_t letter;
		logic    last;
		logic    oor;
	} glyph_t;

	class numeral_board;
		glyph_t  pending[$];
		letter_t spelled[$];
		int      mismatches;
		bit      failed;

		function void append_letter(letter_t l);
			spelled = {spelled, l};
		endfunction

		function void append_glyph(glyph_t g);
			pending = {pending, g};
		endfunction

		function void spell_digit(int unsigned d, letter_t one, letter_t five, letter_t ten);
			unique case (d)
				4: begin
					append_letter(one);
					append_letter(five);
				end
				9: begin
					append_letter(one);
					append_letter(ten);
				end
				default: begin
					if (d >= 5) begin
						append_letter(five);
						d = d - 5;
					end
					repeat (d) append_letter(one);
				end
			endcase
		endfunction

		// Spell the accepted value and queue one expected letter per symbol.
		function void note_value(value_t v);
			int unsigned n;
			glyph_t g;
			n = v;
			spelled.delete();
			if (n == 0 || n > MAX_VALUE) begin
				g = '{CH_NONE, 1'b1, 1'b1};
				append_glyph(g);
				return;
			end
			repeat (n / 1000) append_letter(CH_M);
			spell_digit((n / 100) % 10, CH_C, CH_D, CH_M);
			spell_digit((n / 10) % 10, CH_X, CH_L, CH_C);
			spell_digit(n % 10, CH_I, CH_V, CH_X);
			foreach (spelled[i]) begin
				g = '{spelled[i], (i == spelled.size() - 1), 1'b0};
				append_glyph(g);
			end
		endfunction

		function void check_letter(letter_t l, logic lst, logic oor);
			glyph_t want;
			if (pending.size() == 0) begin
				failed = 1'b1;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer: letter=%h last=%b out_of_range=%b",
						l, lst, oor);
				return;
			end
			want = pending.pop_front();
			if (l !== want.letter || lst !== want.last || oor !== want.oor) begin
				failed = 1'b1;
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch: expected letter=%h last=%b oor=%b, ",
						"got letter=%h last=%b oor=%b"},
						want.letter, want.last, want.oor, l, lst, oor);
			end
		endfunction

		function int outstanding();
			return pending.size();
		endfunction
	endclass

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   in_valid = 1'b0;
	logic   in_ready;
	value_t value = '0;
	logic   out_valid;
	logic   out_ready = 1'b0;
	letter_t letter;
	logic   last;
	logic   out_of_range;

	bit stall_en = 1'b1;
	int cycles = 0;
	numeral_board board = new();

	integer_to_roman_encoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.letter(letter),
		.last(last),
		.out_of_range(out_of_range)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_ready <= stall_en ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_letter(letter, last, out_of_range);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Drive one value and hold it until the transfer.
	task automatic send_value(input value_t v);
		@(negedge clk);
		while (stall_en && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			value <= value_t'($urandom);
			@(negedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		do @(posedge clk); while (!in_ready);
		board.note_value(v);
	endtask

	// Drop valid and hold off until every expected letter has come.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.outstanding() != 0) @(posedge clk);
	endtask

	function automatic value_t pick_value();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 5)
			return '0;
		else if (roll < 11)
			return value_t'($urandom_range(4095, 4000));
		return value_t'($urandom_range(3999, 1));
	endfunction

	task automatic random_burst(input int n);
		repeat (n) send_value(pick_value());
	endtask

	initial begin
		value_t corner[$];
		corner = '{12'd0, 12'd4095, 12'd4000, 12'd3999, 12'd1, 12'd3888, 12'd4, 12'd9,
			12'd40, 12'd90, 12'd400, 12'd900, 12'd5, 12'd10, 12'd50, 12'd100, 12'd500,
			12'd1000, 12'd3000, 12'd1994, 12'd444, 12'd999, 12'd2048, 12'd1365, 12'd2730};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (corner[i]) send_value(corner[i]);
		drain();

		random_burst(120);
		stall_en = 1'b0;
		random_burst(120);
		drain();
		stall_en = 1'b1;
		random_burst(120);
		drain();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (!board.failed && board.outstanding() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
